@@ design/bfca_pkg.sv @@
// Shared types and constants for the best-fit coalescing allocator.
// No dependencies.
package bfca_pkg;

  localparam int unsigned MaxFreeExtents = 16;
  localparam int unsigned AddrBits       = 32;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic clr_scan;   // restart entry index and scan results
    logic scan_a;     // alloc best-fit / release predecessor pass
    logic scan_n;     // release successor pass
    logic commit;     // apply table update and form result
  } bfca_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;       // index is at the final entry
  } bfca_sts_t;

endpackage

@@ design/best_fit_coalescing_allocator.sv @@
// Top level of the best-fit coalescing allocator.
// Depends on bfca_pkg, bfca_ctrl and bfca_datapath.
//
// Slave channel s_axis: one request beat; tuser is func (0 allocate,
// 1 release), tdata packs block_offset then length.
// Master channel m_axis: one response beat per request; tdata packs
// status, granted_offset, granted_length.
// The arena size is written through cfg_we_i/cfg_wdata_i; the user must write
// it only while idle, which the block does not enforce. A write clears the
// free table and, for a nonzero size, enters one extent covering the arena.
// Response valid follows accept after two passes over the table, one entry a
// cycle, then a commit step. One request is handled at a time; the next
// request is accepted only once the response has been taken.
// Reset empties the table and zeroes the arena size.
// A stalled response holds its beat; no new request is taken until it goes.
module best_fit_coalescing_allocator #(
  parameter int unsigned MAX_FREE_EXTENTS = bfca_pkg::MaxFreeExtents,
  parameter int unsigned ADDR_BITS        = bfca_pkg::AddrBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // block_offset[31:0], length[63:32]
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // status[1:0], granted_offset[33:2],
                                      // granted_length[65:34], zero fill
);
  import bfca_pkg::*;

  bfca_cmd_t   cmd;
  bfca_sts_t   sts;
  logic [1:0]  status;
  logic [31:0] goff, glen;

  bfca_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  bfca_datapath #(.N(MAX_FREE_EXTENTS), .W(ADDR_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .func_i(s_axis_tuser), .off_i(s_axis_tdata[31:0]), .len_i(s_axis_tdata[63:32]),
    .cmd_i(cmd), .sts_o(sts),
    .status_o(status), .goff_o(goff), .glen_o(glen)
  );

  assign m_axis_tdata = {6'd0, glen, goff, status};

endmodule

@@ design/bfca_datapath.sv @@
// Free table, request registers and scan logic of the allocator.
// Depends on bfca_pkg.
module bfca_datapath #(
  parameter int unsigned N = bfca_pkg::MaxFreeExtents,
  parameter int unsigned W = bfca_pkg::AddrBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               func_i,
  input  logic [31:0]        off_i,
  input  logic [31:0]        len_i,
  input  bfca_pkg::bfca_cmd_t cmd_i,
  output bfca_pkg::bfca_sts_t sts_o,
  output logic [1:0]         status_o,
  output logic [31:0]        goff_o,
  output logic [31:0]        glen_o
);
  import bfca_pkg::*;

  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;

  logic [W-1:0] start_q [N];
  logic [W-1:0] flen_q  [N];
  logic [N-1:0] valid_q;
  logic [W-1:0] arena_q;

  logic         func_q;
  logic [W-1:0] off_q, len_q;
  logic [IW-1:0] idx_q;

  // scan results
  logic          bf_q;   logic [IW-1:0] bi_q;  // best / predecessor
  logic          nf_q;   logic [IW-1:0] ni_q;  // successor
  logic          sf_q;   logic [IW-1:0] si_q;  // same start (target mo)
  logic          ef_q;   logic [IW-1:0] ei_q;  // first empty
  logic          rf_q;   logic [IW-1:0] ri_q;  // same start for remainder

  logic [W-1:0] cs, cl;
  logic         cv;
  assign cs = start_q[idx_q];
  assign cl = flen_q[idx_q];
  assign cv = valid_q[idx_q];
  assign sts_o.last = (idx_q == IW'(N - 1));

  // predecessor values, merged extent
  logic [W-1:0] ps, pl;
  logic         pm;
  logic [W-1:0] mo, ml;
  assign ps = start_q[bi_q];
  assign pl = flen_q[bi_q];
  assign pm = bf_q && ((ps + pl) == off_q);
  assign mo = pm ? ps : off_q;
  assign ml = pm ? (pl + len_q) : len_q;

  logic [W-1:0] rem_s;
  assign rem_s = start_q[bi_q] + len_q;

  logic [W:0] endsum;
  assign endsum = {1'b0, off_q} + {1'b0, len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      arena_q <= '0;
      idx_q   <= '0;
      bf_q <= 1'b0; nf_q <= 1'b0; sf_q <= 1'b0; ef_q <= 1'b0; rf_q <= 1'b0;
      status_o <= ST_OK;
      goff_o <= '0;
      glen_o <= '0;
    end else begin
      if (cfg_we_i) begin
        arena_q <= W'(cfg_wdata_i);
        valid_q <= '0;
        if (W'(cfg_wdata_i) != '0) begin
          valid_q[0] <= 1'b1;
          start_q[0] <= '0;
          flen_q[0]  <= W'(cfg_wdata_i);
        end
      end
      if (cmd_i.load) begin
        func_q <= func_i;
        off_q  <= W'(off_i);
        len_q  <= W'(len_i);
      end
      if (cmd_i.clr_scan) begin
        idx_q <= '0;
        bf_q <= 1'b0; nf_q <= 1'b0; sf_q <= 1'b0; ef_q <= 1'b0; rf_q <= 1'b0;
      end
      if (cmd_i.scan_a) begin
        idx_q <= sts_o.last ? '0 : idx_q + 1'b1;
        if (!cv && !ef_q) begin
          ef_q <= 1'b1; ei_q <= idx_q;
        end
        if (func_q == FUNC_ALLOC) begin
          if (cv && cl >= len_q &&
              (!bf_q || cl < flen_q[bi_q] ||
               (cl == flen_q[bi_q] && cs < start_q[bi_q]))) begin
            bf_q <= 1'b1; bi_q <= idx_q;
          end
        end else if (cv && cs < off_q && (!bf_q || cs > start_q[bi_q])) begin
          bf_q <= 1'b1; bi_q <= idx_q;
        end
      end
      if (cmd_i.scan_n) begin
        idx_q <= sts_o.last ? '0 : idx_q + 1'b1;
        if (func_q == FUNC_ALLOC) begin
          // look for an entry at the remainder start, ignoring the chosen one
          if (cv && idx_q != bi_q && cs == rem_s && !rf_q) begin
            rf_q <= 1'b1; ri_q <= idx_q;
          end
        end else begin
          if (cv && !(pm && idx_q == bi_q) && cs >= mo &&
              (!nf_q || cs < start_q[ni_q])) begin
            nf_q <= 1'b1; ni_q <= idx_q;
          end
          if (cv && cs == mo && !sf_q) begin
            sf_q <= 1'b1; si_q <= idx_q;
          end
        end
      end
      if (cmd_i.commit) begin
        goff_o <= '0;
        glen_o <= '0;
        status_o <= ST_OK;
        if (func_q == FUNC_ALLOC) begin
          if (len_q == '0) begin
            status_o <= ST_OK;
          end else if (!bf_q) begin
            status_o <= ST_NOFIT;
          end else begin
            goff_o <= 32'(start_q[bi_q]);
            glen_o <= 32'(len_q);
            if (flen_q[bi_q] > len_q) begin
              // remainder reuses the freed slot unless same start exists
              if (rf_q) begin
                valid_q[bi_q] <= 1'b0;
                flen_q[ri_q]  <= flen_q[bi_q] - len_q;
              end else begin
                start_q[bi_q] <= rem_s;
                flen_q[bi_q]  <= flen_q[bi_q] - len_q;
              end
            end else begin
              valid_q[bi_q] <= 1'b0;
            end
          end
        end else if (len_q == '0) begin
          status_o <= ST_OK;
        end else if (endsum > {1'b0, arena_q}) begin
          status_o <= ST_BEYOND;
        end else begin : rel
          logic          nm;
          logic [W-1:0]  fl;
          logic [IW-1:0] tgt;
          nm = nf_q && ((mo + ml) == start_q[ni_q]);
          fl = nm ? (ml + flen_q[ni_q]) : ml;
          if (!pm && !nm && !sf_q && !ef_q) begin
            status_o <= ST_FULL;
          end else begin
            // target: same-start entry if live after clears, else predecessor, else successor, else first free
            if (sf_q && !(nm && si_q == ni_q) && !(pm && si_q == bi_q))
              tgt = si_q;
            else if (pm)
              tgt = bi_q;
            else if (nm)
              tgt = ni_q;
            else
              tgt = ei_q;
            if (nm) valid_q[ni_q] <= 1'b0;
            if (pm) valid_q[bi_q] <= 1'b0;
            valid_q[tgt] <= 1'b1;
            start_q[tgt] <= mo;
            flen_q[tgt]  <= fl;
          end
        end
      end
    end
  end

endmodule

@@ design/bfca_ctrl.sv @@
// Sequencer for the allocator: accept, two table passes, commit, output.
// Depends on bfca_pkg.
module bfca_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bfca_pkg::bfca_sts_t sts_i,
  output bfca_pkg::bfca_cmd_t cmd_o
);
  import bfca_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCA  = 3'd1;
  localparam logic [2:0] S_SCN  = 3'd2;
  localparam logic [2:0] S_COM  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1; cmd_o.clr_scan = 1'b1; state_d = S_SCA;
      end
      S_SCA: begin
        cmd_o.scan_a = 1'b1;
        if (sts_i.last) state_d = S_SCN;
      end
      S_SCN: begin
        cmd_o.scan_n = 1'b1;
        if (sts_i.last) state_d = S_COM;
      end
      S_COM: begin
        cmd_o.commit = 1'b1; state_d = S_OUT;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for best_fit_coalescing_allocator: random and directed
// allocate/release beats checked against a free-extent table kept in the bench.
// Depends on bfca_pkg and the allocator RTL.
module testbench;
  import bfca_pkg::*;

  localparam int NumExt  = MaxFreeExtents;
  localparam int Latency = 2 * NumExt + 3;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic        func;
    logic [31:0] offset;
    logic [31:0] length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] goff;
    logic [31:0] glen;
  } rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  best_fit_coalescing_allocator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Free-extent table mirrored in the bench
  logic [31:0] ext_start [NumExt];
  logic [31:0] ext_len   [NumExt];
  logic        ext_valid [NumExt];
  logic [31:0] arena;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int   errors = 0;
  int   n_sent = 0, n_rcvd = 0, n_alloc_ok = 0, n_merge = 0;
  longint cycles = 0;
  logic allow_hold = 1'b0;
  logic holding = 1'b0;
  logic hold_done = 1'b0;

  initial forever #1 clk_i = ~clk_i;

  function automatic int find_start_idx(logic [31:0] s);
    for (int i = 0; i < NumExt; i++)
      if (ext_valid[i] && ext_start[i] == s) return i;
    return -1;
  endfunction

  function automatic int find_empty_idx();
    for (int i = 0; i < NumExt; i++)
      if (!ext_valid[i]) return i;
    return -1;
  endfunction

  function automatic void record_extent(logic [31:0] s, logic [31:0] l);
    int i;
    i = find_start_idx(s);
    if (i < 0) i = find_empty_idx();
    if (i < 0) return;
    ext_start[i] = s;
    ext_len[i]   = l;
    ext_valid[i] = 1'b1;
  endfunction

  function automatic void reset_table(logic [31:0] size);
    arena = size;
    for (int i = 0; i < NumExt; i++) ext_valid[i] = 1'b0;
    if (size != 0) begin
      ext_start[0] = '0;
      ext_len[0]   = size;
      ext_valid[0] = 1'b1;
    end
  endfunction

  function automatic rsp_t allocate_extent(logic [31:0] len);
    rsp_t r;
    int best;
    logic [31:0] s, l;
    r = '{ST_OK, 32'd0, 32'd0};
    best = -1;
    if (len == 0) return r;
    for (int i = 0; i < NumExt; i++) begin
      if (!ext_valid[i] || ext_len[i] < len) continue;
      if (best < 0 || ext_len[i] < ext_len[best] ||
          (ext_len[i] == ext_len[best] && ext_start[i] < ext_start[best]))
        best = i;
    end
    if (best < 0) begin
      r.status = ST_NOFIT;
      return r;
    end
    s = ext_start[best];
    l = ext_len[best];
    ext_valid[best] = 1'b0;
    if (l > len) record_extent(s + len, l - len);
    r.goff = s;
    r.glen = len;
    return r;
  endfunction

  function automatic rsp_t release_extent(logic [31:0] off, logic [31:0] len);
    rsp_t r;
    int p, n;
    logic pm, nm;
    logic [32:0] mo, ml;
    r = '{ST_OK, 32'd0, 32'd0};
    p = -1;
    n = -1;
    mo = {1'b0, off};
    ml = {1'b0, len};
    if (len == 0) return r;
    if (off > arena || len > arena - off) begin
      r.status = ST_BEYOND;
      return r;
    end
    for (int i = 0; i < NumExt; i++)
      if (ext_valid[i] && ext_start[i] < off && (p < 0 || ext_start[i] > ext_start[p]))
        p = i;
    pm = (p >= 0) && ({1'b0, ext_start[p]} + ext_len[p] == {1'b0, off});
    if (pm) begin
      mo = {1'b0, ext_start[p]};
      ml = ml + ext_len[p];
    end
    for (int i = 0; i < NumExt; i++) begin
      if (!ext_valid[i] || (pm && i == p) || ext_start[i] < mo) continue;
      if (n < 0 || ext_start[i] < ext_start[n]) n = i;
    end
    nm = (n >= 0) && (mo + ml == {1'b0, ext_start[n]});
    if (!pm && !nm && find_start_idx(mo[31:0]) < 0 && find_empty_idx() < 0) begin
      r.status = ST_FULL;
      return r;
    end
    if (nm) begin
      ml = ml + ext_len[n];
      ext_valid[n] = 1'b0;
    end
    if (pm) ext_valid[p] = 1'b0;
    if (pm || nm) n_merge++;
    record_extent(mo[31:0], ml[31:0]);
    return r;
  endfunction

  // Driver: bursts of beats with random gaps
  int gap = 0;
  int burst = 0;
  always @(posedge clk_i) begin
    req_t q;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        q = {s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]};
        expected_rsps.push_back(q.func == FUNC_ALLOC ? allocate_extent(q.length)
                                                     : release_extent(q.offset, q.length));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap > 0) begin
          gap <= gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          q = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= q.func;
          s_axis_tdata  <= {q.length, q.offset};
          if (burst > 0) burst <= burst - 1;
          else begin
            burst <= $urandom_range(12);
            gap   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off when enabled
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (allow_hold && !holding && !hold_done) begin
        holding  <= 1'b1;
        hold_cnt <= 300;
        m_axis_tready <= 1'b0;
      end else if (holding) begin
        hold_cnt <= hold_cnt - 1;
        if (hold_cnt == 1) begin
          holding   <= 1'b0;
          hold_done <= 1'b1;
        end
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ((cycles / 64) % 3 == 0) ? 1'b1 : ($urandom_range(3) != 0);
      end
    end
  end

  // Monitor: compare each response beat with the oldest prediction
  always @(posedge clk_i) begin
    rsp_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[65:34]};
      n_rcvd++;
      if (expected_rsps.size() == 0) begin
        $error("unexpected response beat %h", got);
        errors++;
      end else begin
        want = expected_rsps.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.goff != want.goff) begin
          $error("granted_offset: expected %h, got %h", want.goff, got.goff);
          errors++;
        end
        if (got.glen != want.glen) begin
          $error("granted_length: expected %h, got %h", want.glen, got.glen);
          errors++;
        end
        if (want.status == ST_OK && want.glen != 0) n_alloc_ok++;
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_req(logic func, logic [31:0] off, logic [31:0] len);
    pending_reqs.push_back('{func, off, len});
  endtask

  // Check on the falling edge so that the driver's updates have settled
  task automatic drain();
    @(negedge clk_i);
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
      @(negedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic write_arena(logic [31:0] size);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    reset_table(size);
  endtask

  // Mostly well-formed traffic: random allocates and releases, plus some fully random beats
  task automatic random_phase(int n, logic [31:0] size);
    logic [31:0] len;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      if (k < 4) begin
        len = (size == 0) ? $urandom_range(8) : $urandom_range(size / 4 + 1);
        if ($urandom_range(15) == 0) len = $urandom;
        push_req(FUNC_ALLOC, $urandom, len);
      end else if (k < 8) begin
        // Release chunks of 1 to 64 units at random offsets (offset zero for arenas up to 64)
        len = $urandom_range(1, 64);
        push_req(FUNC_RELEASE, $urandom_range(0, (size > 64) ? size - len : 0), len);
      end else begin
        push_req(1'($urandom_range(1)), $urandom, $urandom);
      end
    end
    drain();
  endtask

  initial begin
    reset_table('0);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero arena
    push_req(FUNC_ALLOC, '0, 32'd5);
    push_req(FUNC_RELEASE, '0, 32'd1);
    push_req(FUNC_ALLOC, '0, 32'd0);
    push_req(FUNC_RELEASE, 32'hFFFF_FFFF, 32'd0);
    drain();

    write_arena(32'd1000);
    push_req(FUNC_ALLOC, 32'hFFFF_FFFF, 32'd100);
    push_req(FUNC_ALLOC, '0, 32'd200);
    push_req(FUNC_ALLOC, '0, 32'd300);
    push_req(FUNC_ALLOC, '0, 32'd1000);
    push_req(FUNC_RELEASE, 32'd100, 32'd200);
    push_req(FUNC_RELEASE, '0, 32'd100);
    push_req(FUNC_RELEASE, 32'd300, 32'd300);
    push_req(FUNC_RELEASE, 32'd990, 32'd11);
    push_req(FUNC_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(FUNC_ALLOC, '0, 32'hFFFF_FFFF);
    push_req(FUNC_RELEASE, 32'd600, 32'd2);
    drain();

    // Fill the table with isolated extents, then overflow it
    write_arena(32'd64);
    push_req(FUNC_ALLOC, '0, 32'd64);
    for (int i = 0; i < NumExt + 2; i++) push_req(FUNC_RELEASE, 2 * i, 32'd1);
    drain();

    write_arena(32'hFFFF_FFFF);
    push_req(FUNC_ALLOC, '0, 32'hFFFF_FFFF);
    push_req(FUNC_RELEASE, 32'h8000_0000, 32'h7FFF_FFFF);
    push_req(FUNC_RELEASE, '0, 32'h8000_0000);
    drain();

    // Random phases under several arena sizes; long hold-off in the first
    allow_hold = 1'b1;
    write_arena(32'd4096);
    random_phase(200, 32'd4096);
    allow_hold = 1'b0;
    write_arena(32'd256);
    random_phase(250, 32'd256);
    write_arena($urandom);
    random_phase(150, arena);
    write_arena(32'd1);
    random_phase(100, 32'd1);
    write_arena('0);
    random_phase(50, 32'd0);

    $display("%0d requests, %0d responses, %0d grants, %0d coalescing releases",
             n_sent, n_rcvd, n_alloc_ok, n_merge);
    $display("arena sizes from zero to full range, table overflow and long stall covered");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
design/bfca_pkg.sv
design/bfca_datapath.sv
design/bfca_ctrl.sv
design/best_fit_coalescing_allocator.sv
tb/testbench.sv
